/* rtl/tdb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Package for the trail decay and 3x3 blur stencil.
// Holds the sizes, value format, register indexes and arithmetic constants.
// No dependencies.
package tdb_pkg;

  localparam int MAX_COLUMNS = 512;
  localparam int MAX_ROWS    = 1024;
  localparam int VALUE_BITS  = 16;

  localparam int COL_BITS    = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS    = $clog2(MAX_ROWS);
  localparam int WIDTH_BITS  = $clog2(MAX_COLUMNS + 1);
  localparam int HEIGHT_BITS = $clog2(MAX_ROWS + 1);

  localparam int ONE_VALUE   = 1 << (VALUE_BITS - 1);
  localparam int WEIGHT_BITS = 9;
  localparam int GREY_BITS   = 8;
  localparam int GREY_MAX    = 255;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_STEP   = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_WEIGHT = 8'd3;

  localparam int RESET_FRAME_WIDTH  = 320;
  localparam int RESET_FRAME_HEIGHT = 180;
  localparam int RESET_DECAY_STEP   = 459;
  localparam int RESET_BLEND_WEIGHT = 77;

  // floor(sum / 9) as (sum * RECIP) >> RECIP_SHIFT, exact over the full sum range
  localparam int SUM_BITS    = VALUE_BITS + 4;
  localparam int RECIP_SHIFT = SUM_BITS + 3;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + 8) / 9;
  localparam int MUL_BITS    = 2 * SUM_BITS;

  localparam int DIFF_BITS   = VALUE_BITS + 1;
  localparam int PROD_BITS   = DIFF_BITS + WEIGHT_BITS + 1;
  localparam int SCALE_BITS  = VALUE_BITS + GREY_BITS;

endpackage : tdb_pkg
`default_nettype wire

/* rtl/tdb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while the read enable is low. No dependencies.
module tdb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tdb_ram
`default_nettype wire

/* rtl/trail_decay_blur_stencil_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Top level of the trail decay and 3x3 box blur stencil.
// Depends on tdb_pkg and on tdb_ram for the two line stores.
//
// Takes one Q1.15 cell per cycle in raster order and returns one result per
// interior cell; border cells give none. Sustained rate is one cell per cycle
// while out_ready stays high. A result reaches the outputs after its closing cell
// (row r+1, column c+1) is accepted, via line store read, decay and window shift,
// 9-cell sum, reciprocal multiply for the mean, blend multiply, then saturation
// and grey scaling into the output register. Line stores are read when a cell is
// accepted and written in the following stage, with a bypass for back-to-back
// cells that land on the same column. Configuration is taken on a separate
// write channel that is always ready; write it only while no transaction is in
// flight.
module trail_decay_blur_stencil_top
  import tdb_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire [CFG_DATA_BITS-1:0]   cfg_data,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire [VALUE_BITS-1:0]      cell_value,
  input  wire                       frame_start,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [VALUE_BITS-1:0]     new_value,
  output logic [GREY_BITS-1:0]      grey_level,
  output logic [ROW_BITS-1:0]       cell_row,
  output logic [COL_BITS-1:0]       cell_col
);

  logic [WIDTH_BITS-1:0]  frame_width;
  logic [HEIGHT_BITS-1:0] frame_height;
  logic [VALUE_BITS-1:0]  decay_step;
  logic [WEIGHT_BITS-1:0] blend_weight;
  logic [WIDTH_BITS-1:0]  w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;

  logic [COL_BITS-1:0] col_count, col_count_next;
  logic [ROW_BITS-1:0] row_count, row_count_next;
  logic [COL_BITS-1:0] c_base, c_in;
  logic [ROW_BITS-1:0] r_base, r_in;
  logic                in_interior, in_emit, in_accept;

  logic                  s1_valid, s1_adv, s1_interior, s1_emit, s1_fwd;
  logic [VALUE_BITS-1:0] s1_value, s1_fwd_up, s1_fwd_mid;
  logic [COL_BITS-1:0]   s1_col, s1_col_out;
  logic [ROW_BITS-1:0]   s1_row_out;
  logic [DIFF_BITS-1:0]  s1_diff;
  logic [VALUE_BITS-1:0] s1_decayed, s1_up, s1_mid, rd_up, rd_mid;

  logic                  s2_valid, s2_adv, s2_emit;
  logic [VALUE_BITS-1:0] window [9];
  logic [COL_BITS-1:0]   s2_col;
  logic [ROW_BITS-1:0]   s2_row;
  logic [SUM_BITS-1:0]   s2_sum;

  logic                  s3_valid, s3_adv;
  logic [SUM_BITS-1:0]   s3_sum;
  logic [VALUE_BITS-1:0] s3_centre;
  logic [COL_BITS-1:0]   s3_col;
  logic [ROW_BITS-1:0]   s3_row;
  logic [MUL_BITS-1:0]   s3_prod;

  logic                        s4_valid, s4_adv;
  logic [VALUE_BITS-1:0]       s4_mean, s4_centre;
  logic [COL_BITS-1:0]         s4_col;
  logic [ROW_BITS-1:0]         s4_row;
  logic signed [DIFF_BITS-1:0] s4_diff;
  logic signed [PROD_BITS-1:0] s4_weighted;

  logic                        s5_valid, s5_adv;
  logic signed [PROD_BITS-1:0] s5_weighted, s5_blended;
  logic [VALUE_BITS-1:0]       s5_centre, s5_res;
  logic [COL_BITS-1:0]         s5_col;
  logic [ROW_BITS-1:0]         s5_row;
  logic [SCALE_BITS-1:0]       s5_scaled;
  logic [GREY_BITS-1:0]        s5_grey;

  logic out_adv;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_BITS'(RESET_FRAME_WIDTH);
      frame_height <= HEIGHT_BITS'(RESET_FRAME_HEIGHT);
      decay_step   <= VALUE_BITS'(RESET_DECAY_STEP);
      blend_weight <= WEIGHT_BITS'(RESET_BLEND_WEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_BITS-1:0];
        REG_DECAY_STEP:   decay_step   <= cfg_data[VALUE_BITS-1:0];
        REG_BLEND_WEIGHT: blend_weight <= cfg_data[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < WIDTH_BITS'(3)) w_eff = WIDTH_BITS'(3);
    else if (frame_width > WIDTH_BITS'(MAX_COLUMNS)) w_eff = WIDTH_BITS'(MAX_COLUMNS);
    else w_eff = frame_width;
    if (frame_height < HEIGHT_BITS'(3)) h_eff = HEIGHT_BITS'(3);
    else if (frame_height > HEIGHT_BITS'(MAX_ROWS)) h_eff = HEIGHT_BITS'(MAX_ROWS);
    else h_eff = frame_height;
  end

  // handshake chain
  assign out_adv  = out_valid && out_ready;
  assign s5_adv   = s5_valid && (!out_valid || out_adv);
  assign s4_adv   = s4_valid && (!s5_valid || s5_adv);
  assign s3_adv   = s3_valid && (!s4_valid || s4_adv);
  assign s2_adv   = s2_valid && (!s2_emit || !s3_valid || s3_adv);
  assign s1_adv   = s1_valid && (!s2_valid || s2_adv);
  assign in_ready = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;

  // position of the incoming cell
  always_comb begin
    c_base = frame_start ? '0 : col_count;
    r_base = frame_start ? '0 : row_count;
    c_in   = ({1'b0, c_base} >= w_eff) ? '0 : c_base;
    r_in   = ({1'b0, r_base} >= h_eff) ? '0 : r_base;
    if (({1'b0, c_in} + WIDTH_BITS'(1)) >= w_eff) begin
      col_count_next = '0;
      row_count_next = (({1'b0, r_in} + HEIGHT_BITS'(1)) >= h_eff) ? '0 : r_in + ROW_BITS'(1);
    end else begin
      col_count_next = c_in + COL_BITS'(1);
      row_count_next = r_in;
    end
    in_interior = (r_in >= ROW_BITS'(1)) && ({1'b0, r_in} <= h_eff - HEIGHT_BITS'(2)) &&
                  (c_in >= COL_BITS'(1)) && ({1'b0, c_in} <= w_eff - WIDTH_BITS'(2));
    in_emit = (r_in >= ROW_BITS'(2)) && (c_in >= COL_BITS'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // stage 1: line store data, decay, line store write
  tdb_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_COLUMNS)) u_line_upper (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_mid),
    .re    (in_accept),
    .raddr (c_in),
    .rdata (rd_up)
  );

  tdb_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_COLUMNS)) u_line_middle (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_decayed),
    .re    (in_accept),
    .raddr (c_in),
    .rdata (rd_mid)
  );

  always_comb begin
    s1_diff = {1'b0, s1_value} - {1'b0, decay_step};
    if (!s1_interior) s1_decayed = s1_value;
    else if (s1_diff[DIFF_BITS-1] || s1_diff[VALUE_BITS-1]) s1_decayed = '0;
    else s1_decayed = s1_diff[VALUE_BITS-1:0];
    s1_up  = s1_fwd ? s1_fwd_up  : rd_up;
    s1_mid = s1_fwd ? s1_fwd_mid : rd_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s1_adv) begin
      s1_valid <= in_accept;
    end
    if (in_accept) begin
      s1_value    <= cell_value;
      s1_interior <= in_interior;
      s1_emit     <= in_emit;
      s1_col      <= c_in;
      s1_col_out  <= c_in - COL_BITS'(1);
      s1_row_out  <= r_in - ROW_BITS'(1);
      // bypass the write landing at this edge on the same column
      s1_fwd      <= s1_valid && (s1_col == c_in);
      s1_fwd_up   <= s1_mid;
      s1_fwd_mid  <= s1_decayed;
    end
  end

  // stage 2: window shift and neighborhood sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        window[i] <= '0;
      end
    end else begin
      if (!s2_valid || s2_adv) begin
        s2_valid <= s1_adv;
      end
      if (s1_adv) begin
        for (int i = 0; i < 3; i++) begin
          window[i*3]   <= window[i*3+1];
          window[i*3+1] <= window[i*3+2];
        end
        window[2] <= s1_up;
        window[5] <= s1_mid;
        window[8] <= s1_decayed;
      end
    end
    if (s1_adv) begin
      s2_emit <= s1_emit;
      s2_col  <= s1_col_out;
      s2_row  <= s1_row_out;
    end
  end

  assign s2_sum = (SUM_BITS'(window[0]) + SUM_BITS'(window[1]) + SUM_BITS'(window[2])) +
                  (SUM_BITS'(window[3]) + SUM_BITS'(window[4]) + SUM_BITS'(window[5])) +
                  (SUM_BITS'(window[6]) + SUM_BITS'(window[7]) + SUM_BITS'(window[8]));

  // stage 3: mean by reciprocal multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (!s3_valid || s3_adv) begin
      s3_valid <= s2_adv && s2_emit;
    end
    if (s2_adv && s2_emit) begin
      s3_sum    <= s2_sum;
      s3_centre <= window[4];
      s3_col    <= s2_col;
      s3_row    <= s2_row;
    end
  end

  assign s3_prod = MUL_BITS'(s3_sum) * MUL_BITS'(RECIP);

  // stage 4: blend multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (!s4_valid || s4_adv) begin
      s4_valid <= s3_adv;
    end
    if (s3_adv) begin
      s4_mean   <= s3_prod[RECIP_SHIFT+VALUE_BITS-1:RECIP_SHIFT];
      s4_centre <= s3_centre;
      s4_col    <= s3_col;
      s4_row    <= s3_row;
    end
  end

  assign s4_diff     = $signed({1'b0, s4_mean}) - $signed({1'b0, s4_centre});
  assign s4_weighted = PROD_BITS'($signed({1'b0, blend_weight})) * PROD_BITS'(s4_diff);

  // stage 5: floor shift, saturate, grey scale
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (!s5_valid || s5_adv) begin
      s5_valid <= s4_adv;
    end
    if (s4_adv) begin
      s5_weighted <= s4_weighted;
      s5_centre   <= s4_centre;
      s5_col      <= s4_col;
      s5_row      <= s4_row;
    end
  end

  always_comb begin
    s5_blended = $signed({{(PROD_BITS-VALUE_BITS){1'b0}}, s5_centre}) + (s5_weighted >>> 8);
    if (s5_blended[PROD_BITS-1]) s5_res = '0;
    else if (s5_blended > $signed(PROD_BITS'(ONE_VALUE))) s5_res = VALUE_BITS'(ONE_VALUE);
    else s5_res = s5_blended[VALUE_BITS-1:0];
    s5_scaled = {s5_res, {GREY_BITS{1'b0}}} - {{GREY_BITS{1'b0}}, s5_res};
    if (s5_scaled[SCALE_BITS-1:VALUE_BITS-1] > (SCALE_BITS-VALUE_BITS+1)'(GREY_MAX)) begin
      s5_grey = GREY_BITS'(GREY_MAX);
    end else begin
      s5_grey = s5_scaled[VALUE_BITS+GREY_BITS-2:VALUE_BITS-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_adv) begin
      out_valid <= s5_adv;
    end
    if (s5_adv) begin
      new_value  <= s5_res;
      grey_level <= s5_grey;
      cell_row   <= s5_row;
      cell_col   <= s5_col;
    end
  end

  // assertions
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> ({1'b0, col_count} < $past(w_eff)))
    else $error("column counter beyond frame width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> ({1'b0, row_count} < $past(h_eff)))
    else $error("row counter beyond frame height");

  a_grey_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((new_value == VALUE_BITS'(ONE_VALUE)) ==
                   (grey_level == GREY_BITS'(GREY_MAX))))
    else $error("grey level disagrees with full intensity");

  a_emit_interior: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_row != '0) && (s3_col != '0))
    else $error("result issued for a border cell");

endmodule : trail_decay_blur_stencil_top
`default_nettype wire
